// ===== rtl/core/xxh64ws_pkg.sv =====
// ----------------------------------------------------------------------------
// xxh64ws_pkg
// Shared types, constants and helpers for the xxHash64 word stream core.
// ----------------------------------------------------------------------------
package xxh64ws_pkg;

  localparam int COUNT_WIDTH = 61;

  localparam logic [63:0] PRIME1 = 64'h9E3779B185EBCA87;
  localparam logic [63:0] PRIME2 = 64'hC2B2AE3D27D4EB4F;
  localparam logic [63:0] PRIME3 = 64'h165667B19E3779F9;
  localparam logic [63:0] PRIME4 = 64'h85EBCA77C2B2AE63;
  localparam logic [63:0] PRIME5 = 64'h27D4EB2F165667C5;

  // last step numbers of each sequence
  localparam logic [3:0] ROUND_LAST = 4'd8;
  localparam logic [3:0] MERGE_LAST = 4'd11;
  localparam logic [3:0] TAIL_LAST  = 4'd12;
  localparam logic [3:0] AVAL_LAST  = 4'd8;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ROUND,
    S_INIT,
    S_MERGE,
    S_LEN,
    S_TAIL,
    S_AVAL,
    S_DONE
  } ctrl_state_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_MUL,
    OP_LOAD_LANES,
    OP_T_ADD_LANE,
    OP_LANE_PROD,
    OP_H_INIT,
    OP_T_ROT31_PROD,
    OP_H_XOR_PROD,
    OP_H_ADD_P4,
    OP_H_ADD_LEN,
    OP_T_ROT27_H,
    OP_H_XS33,
    OP_H_PXS29,
    OP_H_PXS32,
    OP_EMIT
  } dp_op_t;

  typedef enum logic [2:0] {
    A_WORD,
    A_PEND,
    A_LANE,
    A_T,
    A_H
  } a_sel_t;

  typedef enum logic [1:0] {
    K_P1,
    K_P2,
    K_P3
  } k_sel_t;

  typedef struct packed {
    logic       accept;
    dp_op_t     op;
    logic [1:0] phase;
    a_sel_t     a_sel;
    k_sel_t     k_sel;
    logic [1:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic       grouped;
    logic [1:0] group_pos;
    logic       out_free;
  } dp_status_t;

  function automatic logic [63:0] rotl64(input logic [63:0] v, input int r);
    rotl64 = (v << r) | (v >> (64 - r));
  endfunction

endpackage

// ===== rtl/core/xxh64ws_dp.sv =====
// ----------------------------------------------------------------------------
// xxh64ws_dp
// Datapath: lane and pending word stores, one shared 32x32 multiplier
// building 64-bit products in three passes, and the output register.
// ----------------------------------------------------------------------------
module xxh64ws_dp (
  input  logic                    clk,
  input  logic                    rst,
  input  xxh64ws_pkg::dp_cmd_t    cmd,
  output xxh64ws_pkg::dp_status_t status,
  input  logic [63:0]             word,
  input  logic                    empty_req,
  input  logic                    cfg_valid,
  input  logic [63:0]             seed,
  output logic [63:0]             hash,
  output logic                    out_valid,
  input  logic                    out_stall
);
  import xxh64ws_pkg::*;

  logic [63:0] seed_r;
  logic [63:0] h;
  logic [63:0] t;
  logic [63:0] prod;
  logic [63:0] wreg;
  logic [63:0] lane [4];
  logic [63:0] pend [3];
  logic [COUNT_WIDTH-1:0] count;
  logic [1:0]  group_pos;
  logic        grouped;

  logic [63:0] mul_a;
  logic [63:0] mul_k;
  logic [31:0] ma;
  logic [31:0] mb;
  logic [63:0] pp;
  logic        out_free;

  // multiplier operand selection
  always_comb begin
    unique case (cmd.a_sel)
      A_WORD:  mul_a = wreg;
      A_PEND:  mul_a = pend[cmd.idx];
      A_LANE:  mul_a = lane[cmd.idx];
      A_T:     mul_a = t;
      A_H:     mul_a = h;
      default: mul_a = h;
    endcase
    unique case (cmd.k_sel)
      K_P1:    mul_k = PRIME1;
      K_P2:    mul_k = PRIME2;
      K_P3:    mul_k = PRIME3;
      default: mul_k = PRIME1;
    endcase
  end

  // low x low, low x high, high x low partial products
  assign ma = (cmd.phase == 2'd2) ? mul_a[63:32] : mul_a[31:0];
  assign mb = (cmd.phase == 2'd1) ? mul_k[63:32] : mul_k[31:0];
  assign pp = {32'b0, ma} * {32'b0, mb};

  assign out_free = !out_valid || !out_stall;
  assign status   = '{grouped: grouped, group_pos: group_pos, out_free: out_free};

  // control state of the message
  always_ff @(posedge clk) begin
    if (rst) begin
      seed_r    <= '0;
      count     <= '0;
      group_pos <= '0;
      grouped   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        seed_r <= seed;
      end
      if (cmd.accept && !empty_req) begin
        group_pos <= (group_pos == 2'd3) ? 2'd0 : group_pos + 2'd1;
        count     <= count + 1'b1;
      end
      if (cmd.op == OP_LOAD_LANES) begin
        grouped <= 1'b1;
      end
      if (cmd.op == OP_EMIT) begin
        count     <= '0;
        group_pos <= '0;
        grouped   <= 1'b0;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept && !empty_req) begin
      if (group_pos == 2'd3) begin
        wreg <= word;
      end else begin
        pend[group_pos] <= word;
      end
    end
    unique case (cmd.op)
      OP_MUL: begin
        prod <= (cmd.phase == 2'd0) ? pp : prod + {pp[31:0], 32'b0};
      end
      OP_LOAD_LANES: begin
        if (!grouped) begin
          lane[0] <= seed_r + PRIME1 + PRIME2;
          lane[1] <= seed_r + PRIME2;
          lane[2] <= seed_r;
          lane[3] <= seed_r - PRIME1;
        end
      end
      OP_T_ADD_LANE:   t <= rotl64(lane[cmd.idx] + prod, 31);
      OP_LANE_PROD:    lane[cmd.idx] <= prod;
      OP_H_INIT: begin
        if (grouped) begin
          h <= rotl64(lane[0], 1) + rotl64(lane[1], 7) +
               rotl64(lane[2], 12) + rotl64(lane[3], 18);
        end else begin
          h <= seed_r + PRIME5;
        end
      end
      OP_T_ROT31_PROD: t <= rotl64(prod, 31);
      OP_H_XOR_PROD:   h <= h ^ prod;
      OP_H_ADD_P4:     h <= prod + PRIME4;
      OP_H_ADD_LEN:    h <= h + (64'(count) << 3);
      OP_T_ROT27_H:    t <= rotl64(h, 27);
      OP_H_XS33:       h <= h ^ (h >> 33);
      OP_H_PXS29:      h <= prod ^ (prod >> 29);
      OP_H_PXS32:      h <= prod ^ (prod >> 32);
      OP_EMIT:         hash <= h;
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  // a result is only loaded into a free output register
  assert property (@(posedge clk) disable iff (rst) (cmd.op == OP_EMIT) |-> out_free)
    else $error("emit into occupied output register");

  // a finished message leaves no words behind
  assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_EMIT) |=> (group_pos == 2'd0 && !grouped))
    else $error("message state not cleared after emit");

  // a waiting result holds while stalled
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(hash)))
    else $error("stalled result changed");
`endif

endmodule

// ===== rtl/core/xxh64ws_ctrl.sv =====
// ----------------------------------------------------------------------------
// xxh64ws_ctrl
// Controller: sequences lane rounds, lane merge, tail folding and avalanche
// through the datapath, one command per cycle.
// ----------------------------------------------------------------------------
module xxh64ws_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    last,
  input  logic                    empty_req,
  input  xxh64ws_pkg::dp_status_t status,
  output xxh64ws_pkg::dp_cmd_t    cmd
);
  import xxh64ws_pkg::*;

  ctrl_state_t state, state_next;
  logic [3:0]  step, step_next;
  logic [1:0]  idx, idx_next;
  logic        last_r, last_r_next;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      step   <= '0;
      idx    <= '0;
      last_r <= 1'b0;
    end else begin
      state  <= state_next;
      step   <= step_next;
      idx    <= idx_next;
      last_r <= last_r_next;
    end
  end

  // next state
  always_comb begin
    state_next  = state;
    step_next   = step + 4'd1;
    idx_next    = idx;
    last_r_next = last_r;
    unique case (state)
      S_IDLE: begin
        step_next = '0;
        idx_next  = '0;
        if (in_valid) begin
          if (empty_req) begin
            state_next = S_INIT;
          end else if (status.group_pos == 2'd3) begin
            state_next  = S_ROUND;
            last_r_next = last;
          end else if (last) begin
            state_next = S_INIT;
          end
        end
      end
      S_ROUND: begin
        if (step == ROUND_LAST) begin
          step_next = '0;
          idx_next  = idx + 2'd1;
          if (idx == 2'd3) begin
            state_next = last_r ? S_INIT : S_IDLE;
          end
        end
      end
      S_INIT: begin
        step_next  = '0;
        idx_next   = '0;
        state_next = status.grouped ? S_MERGE : S_LEN;
      end
      S_MERGE: begin
        if (step == MERGE_LAST) begin
          step_next = '0;
          idx_next  = idx + 2'd1;
          if (idx == 2'd3) begin
            state_next = S_LEN;
          end
        end
      end
      S_LEN: begin
        step_next  = '0;
        idx_next   = '0;
        state_next = (status.group_pos != 2'd0) ? S_TAIL : S_AVAL;
      end
      S_TAIL: begin
        if (step == TAIL_LAST) begin
          step_next = '0;
          idx_next  = idx + 2'd1;
          if (idx + 2'd1 == status.group_pos) begin
            state_next = S_AVAL;
          end
        end
      end
      S_AVAL: begin
        if (step == AVAL_LAST) begin
          step_next  = '0;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        step_next = '0;
        if (status.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    in_stall   = (state != S_IDLE);
    cmd        = '{accept: 1'b0, op: OP_NOP, phase: 2'd0, a_sel: A_H,
                   k_sel: K_P1, idx: idx};
    cmd.accept = (state == S_IDLE) && in_valid;
    unique case (state)
      S_IDLE: ;
      S_ROUND: begin
        unique case (step)
          4'd0: cmd.op = OP_LOAD_LANES;
          4'd1, 4'd2, 4'd3: begin
            cmd.op    = OP_MUL;
            cmd.phase = 2'(step - 4'd1);
            cmd.a_sel = (idx == 2'd3) ? A_WORD : A_PEND;
            cmd.k_sel = K_P2;
          end
          4'd4: cmd.op = OP_T_ADD_LANE;
          4'd5, 4'd6, 4'd7: begin
            cmd.op    = OP_MUL;
            cmd.phase = 2'(step - 4'd5);
            cmd.a_sel = A_T;
            cmd.k_sel = K_P1;
          end
          4'd8:    cmd.op = OP_LANE_PROD;
          default: cmd.op = OP_NOP;
        endcase
      end
      S_INIT: cmd.op = OP_H_INIT;
      S_MERGE: begin
        unique case (step)
          4'd0, 4'd1, 4'd2: begin
            cmd.op    = OP_MUL;
            cmd.phase = 2'(step);
            cmd.a_sel = A_LANE;
            cmd.k_sel = K_P2;
          end
          4'd3: cmd.op = OP_T_ROT31_PROD;
          4'd4, 4'd5, 4'd6: begin
            cmd.op    = OP_MUL;
            cmd.phase = 2'(step - 4'd4);
            cmd.a_sel = A_T;
            cmd.k_sel = K_P1;
          end
          4'd7: cmd.op = OP_H_XOR_PROD;
          4'd8, 4'd9, 4'd10: begin
            cmd.op    = OP_MUL;
            cmd.phase = 2'(step - 4'd8);
            cmd.a_sel = A_H;
            cmd.k_sel = K_P1;
          end
          4'd11:   cmd.op = OP_H_ADD_P4;
          default: cmd.op = OP_NOP;
        endcase
      end
      S_LEN: cmd.op = OP_H_ADD_LEN;
      S_TAIL: begin
        unique case (step)
          4'd0, 4'd1, 4'd2: begin
            cmd.op    = OP_MUL;
            cmd.phase = 2'(step);
            cmd.a_sel = A_PEND;
            cmd.k_sel = K_P2;
          end
          4'd3: cmd.op = OP_T_ROT31_PROD;
          4'd4, 4'd5, 4'd6: begin
            cmd.op    = OP_MUL;
            cmd.phase = 2'(step - 4'd4);
            cmd.a_sel = A_T;
            cmd.k_sel = K_P1;
          end
          4'd7: cmd.op = OP_H_XOR_PROD;
          4'd8: cmd.op = OP_T_ROT27_H;
          4'd9, 4'd10, 4'd11: begin
            cmd.op    = OP_MUL;
            cmd.phase = 2'(step - 4'd9);
            cmd.a_sel = A_T;
            cmd.k_sel = K_P1;
          end
          4'd12:   cmd.op = OP_H_ADD_P4;
          default: cmd.op = OP_NOP;
        endcase
      end
      S_AVAL: begin
        unique case (step)
          4'd0: cmd.op = OP_H_XS33;
          4'd1, 4'd2, 4'd3: begin
            cmd.op    = OP_MUL;
            cmd.phase = 2'(step - 4'd1);
            cmd.a_sel = A_H;
            cmd.k_sel = K_P2;
          end
          4'd4: cmd.op = OP_H_PXS29;
          4'd5, 4'd6, 4'd7: begin
            cmd.op    = OP_MUL;
            cmd.phase = 2'(step - 4'd5);
            cmd.a_sel = A_H;
            cmd.k_sel = K_P3;
          end
          4'd8:    cmd.op = OP_H_PXS32;
          default: cmd.op = OP_NOP;
        endcase
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.op = OP_EMIT;
        end
      end
      default: cmd.op = OP_NOP;
    endcase
  end

`ifndef SYNTHESIS
  // an empty request always starts finalization
  assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && in_valid && empty_req) |=> (state == S_INIT))
    else $error("empty request did not start finalization");

  // the tail only visits pending words that exist
  assert property (@(posedge clk) disable iff (rst)
    (state == S_TAIL) |-> (idx < status.group_pos))
    else $error("tail index past pending words");

  // a finished hash leaves once the output register frees up
  assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && status.out_free) |=> (state == S_IDLE))
    else $error("finished hash not emitted");
`endif

endmodule

// ===== rtl/core/xxhash64_word_stream_core.sv =====
// ----------------------------------------------------------------------------
// xxhash64_word_stream_core
// xxHash64 over a stream of whole 64-bit words under a configurable seed.
// ----------------------------------------------------------------------------
// A word that does not complete a group of four is taken without a stall. The
// word that completes a group stalls intake while the four lane rounds run on a
// single shared 32x32 multiplier that builds each 64-bit product in three
// passes. Ending a message runs the hash init, the lane merge (when four or
// more words were seen), the length add, one tail fold per leftover word (0 to
// 3), the avalanche, and the emit after any wait for the output register to
// drain; intake is stalled during that time. One result register sits on the
// output, so a hash can wait there while the next message streams in.
// ----------------------------------------------------------------------------
module xxhash64_word_stream_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] word,
  input  logic        last,
  input  logic        empty_req,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] hash,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] seed
);
  import xxh64ws_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // seed register is always writable
  assign cfg_ready = 1'b1;

  // controller
  xxh64ws_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .last      (last),
    .empty_req (empty_req),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath
  xxh64ws_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .word      (word),
    .empty_req (empty_req),
    .cfg_valid (cfg_valid),
    .seed      (seed),
    .hash      (hash),
    .out_valid (out_valid),
    .out_stall (out_stall)
  );

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the xxHash64 word stream core: drives messages of
// whole words under several seeds, predicts each hash and compares results.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import xxh64ws_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MASK = '1;
  localparam int CYCLE_LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [63:0] word = '0;
  logic last = 1'b0;
  logic empty_req = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [63:0] hash;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [63:0] seed = '0;

  // predictor state
  logic [63:0] cur_seed;
  logic [63:0] lanes [4];
  logic [63:0] pend [3];
  logic [COUNT_WIDTH-1:0] nwords;
  int unsigned gpos;
  bit grouped;

  logic [63:0] hash_queue [$];
  int errors = 0;
  int n_items = 0;
  int n_hashes = 0;
  int n_msgs = 0;
  longint cycles = 0;
  bit stall_en = 1'b1;

  xxhash64_word_stream_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .word(word), .last(last), .empty_req(empty_req),
    .out_valid(out_valid), .out_stall(out_stall), .hash(hash),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .seed(seed)
  );

  always #5 clk = ~clk;

  function automatic logic [63:0] rol(logic [63:0] v, int r);
    return (v << r) | (v >> (64 - r));
  endfunction

  function automatic logic [63:0] lane_mix(logic [63:0] acc, logic [63:0] w);
    logic [63:0] a;
    a = acc + w * PRIME2;
    return rol(a, 31) * PRIME1;
  endfunction

  task automatic reload_lanes();
    lanes[0] = cur_seed + PRIME1 + PRIME2;
    lanes[1] = cur_seed + PRIME2;
    lanes[2] = cur_seed;
    lanes[3] = cur_seed - PRIME1;
  endtask

  task automatic finish_hash();
    logic [63:0] h;
    if (grouped) begin
      h = rol(lanes[0], 1) + rol(lanes[1], 7) + rol(lanes[2], 12) + rol(lanes[3], 18);
      for (int i = 0; i < 4; i++) begin
        h ^= lane_mix(64'd0, lanes[i]);
        h = h * PRIME1 + PRIME4;
      end
    end else begin
      h = cur_seed + PRIME5;
    end
    h += {nwords, 3'b000};
    for (int i = 0; i < gpos; i++) begin
      h ^= lane_mix(64'd0, pend[i]);
      h = rol(h, 27) * PRIME1 + PRIME4;
    end
    h ^= h >> 33;
    h *= PRIME2;
    h ^= h >> 29;
    h *= PRIME3;
    h ^= h >> 32;
    hash_queue.push_back(h);
    nwords = '0;
    gpos = 0;
    grouped = 1'b0;
  endtask

  task automatic predict_word(logic [63:0] w, bit l, bit e);
    if (e) begin
      finish_hash();
      return;
    end
    if (gpos < 3) begin
      pend[gpos] = w;
      gpos++;
    end else begin
      if (!grouped) reload_lanes();
      lanes[0] = lane_mix(lanes[0], pend[0]);
      lanes[1] = lane_mix(lanes[1], pend[1]);
      lanes[2] = lane_mix(lanes[2], pend[2]);
      lanes[3] = lane_mix(lanes[3], w);
      gpos = 0;
      grouped = 1'b1;
    end
    nwords = (nwords + 1'b1) & COUNT_MASK;
    if (l) finish_hash();
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // send one word transaction and update the prediction on acceptance
  // valid stays up between back-to-back transactions
  task automatic send_word(logic [63:0] w, bit l, bit e);
    int g;
    g = gap_len();
    if (g != 0) begin
      in_valid <= 1'b0;
      word <= {$urandom, $urandom};
      last <= 1'($urandom_range(0, 1));
      empty_req <= 1'($urandom_range(0, 1));
      repeat (g) @(negedge clk);
    end
    in_valid <= 1'b1;
    word <= w;
    last <= l;
    empty_req <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_word(w, l, e);
    n_items++;
    @(negedge clk);
  endtask

  task automatic send_msg(int len, bit use_empty_end);
    for (int i = 0; i < len; i++)
      send_word({$urandom, $urandom}, (i == len - 1) && !use_empty_end, 1'b0);
    if (use_empty_end || len == 0)
      send_word({$urandom, $urandom}, 1'($urandom_range(0, 1)), 1'b1);
    n_msgs++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (hash_queue.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  // write the seed while the core is idle
  task automatic write_seed(logic [63:0] s);
    cfg_valid <= 1'b1;
    seed <= s;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cur_seed = s;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // output stall and result check
  always @(negedge clk) begin
    if (rst || !stall_en) out_stall <= 1'b0;
    else out_stall <= (gap_len() != 0);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && out_valid && !out_stall) begin
      if (hash_queue.size() == 0) begin
        $error("unexpected hash %h", hash);
        errors++;
      end else begin
        if (hash !== hash_queue[0]) begin
          $error("field hash: expected %h actual %h", hash_queue[0], hash);
          errors++;
        end
        void'(hash_queue.pop_front());
        n_hashes++;
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic test_directed();
    write_seed(64'd0);
    send_word(64'd0, 1'b0, 1'b1);               // empty message
    send_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0);
    send_word(64'd0, 1'b1, 1'b0);
    send_word(64'h1, 1'b0, 1'b0);
    send_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0);
    send_word(64'h8000_0000_0000_0000, 1'b1, 1'b0);
    send_msg(4, 1'b0);
    send_msg(5, 1'b0);
    send_word(64'h5, 1'b0, 1'b0);
    send_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1); // empty wins over last
    drain();
    write_seed(64'hFFFF_FFFF_FFFF_FFFF);
    send_word(64'd0, 1'b0, 1'b1);
    send_msg(7, 1'b1);                          // empty ends message mid-way
    drain();
  endtask

  task automatic test_seed_midmessage();
    write_seed(64'h0123_4567_89AB_CDEF);
    send_msg(2, 1'b0);
    send_word({$urandom, $urandom}, 1'b0, 1'b0);
    send_word({$urandom, $urandom}, 1'b0, 1'b0);
    drain();
    write_seed({$urandom, $urandom});           // lanes load at first group
    send_word({$urandom, $urandom}, 1'b0, 1'b0);
    send_word({$urandom, $urandom}, 1'b0, 1'b0);
    drain();
    write_seed({$urandom, $urandom});
    send_word({$urandom, $urandom}, 1'b1, 1'b0);
    drain();
  endtask

  task automatic test_random();
    int len;
    for (int ph = 0; ph < 4; ph++) begin
      write_seed(ph == 0 ? 64'd0 : {$urandom, $urandom});
      stall_en = (ph != 2);
      while (n_items < 300 * (ph + 1) + 40) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(0, 8);
        send_msg(len, $urandom_range(0, 5) == 0);
        if ($urandom_range(0, 30) == 0) drain();
      end
      drain();
    end
  endtask

  initial begin
    cur_seed = '0;
    nwords = '0;
    gpos = 0;
    grouped = 1'b0;
    reload_lanes();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_seed_midmessage();
    test_random();
    drain();
    $display("covered %0d words in %0d messages, %0d hashes checked", n_items, n_msgs,
             n_hashes);
    $display("seeds included zero, all-ones, mid-message changes and random values");
    if (errors == 0 && hash_queue.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
